// File: rtl/sfpc_pkg.sv
`timescale 1ns / 1ps

package sfpc_pkg;

    // Configuration port address width: seven word registers.
    localparam int CfgAddrW = 5;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_POWER_ON  = 2'd0;
    localparam logic [1:0] CMD_SHUT_DOWN = 2'd1;
    localparam logic [1:0] CMD_MOVE      = 2'd2;
    localparam logic [1:0] CMD_MODE      = 2'd3;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_STEP_NUM = 3'd0;
    localparam logic [2:0] REG_STEP_DEN = 3'd1;
    localparam logic [2:0] REG_FULL     = 3'd2;
    localparam logic [2:0] REG_DIR_INV  = 3'd3;
    localparam logic [2:0] REG_EN_LEVEL = 3'd4;
    localparam logic [2:0] REG_INIT_NUM = 3'd5;
    localparam logic [2:0] REG_INIT_DEN = 3'd6;

    // Operations of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_TN_CD,
        MUL_DNUM,
        MUL_DDEN,
        MUL_FS,
        MUL_DV,
        MUL_TOP
    } mul_op_t;

    // Register file contents seen by the datapath.
    typedef struct packed {
        logic signed [15:0] step_num;
        logic signed [15:0] step_den;
        logic        [15:0] full_angle;
        logic               dir_invert;
        logic               en_active;
        logic               load_num;
        logic               load_den;
        logic signed [15:0] init_num;
        logic signed [15:0] init_den;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    mul_en;
        mul_op_t mul_op;
        logic    abs_en;
        logic    div_step;
        logic    commit;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       reject;
        logic       degenerate;
    } sts_t;

endpackage

// File: rtl/sfpc_regs.sv
`timescale 1ns / 1ps

module sfpc_regs import sfpc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output cfg_t                cfg
);

    logic        [15:0] step_num_reg;
    logic        [15:0] step_den_reg;
    logic        [15:0] full_reg;
    logic               dir_inv_reg;
    logic               en_level_reg;
    logic        [15:0] init_num_reg;
    logic        [15:0] init_den_reg;
    logic               wr;
    logic        [2:0]  idx;

    assign idx = paddr[CfgAddrW-1:2];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_num_reg <= 16'd9;
            step_den_reg <= 16'd5;
            full_reg     <= 16'd360;
            dir_inv_reg  <= 1'b0;
            en_level_reg <= 1'b1;
            init_num_reg <= 16'd0;
            init_den_reg <= 16'd1;
        end else if (wr) begin
            unique case (idx)
                REG_STEP_NUM: step_num_reg <= pwdata[15:0];
                REG_STEP_DEN: step_den_reg <= pwdata[15:0];
                REG_FULL:     full_reg     <= pwdata[15:0];
                REG_DIR_INV:  dir_inv_reg  <= pwdata[0];
                REG_EN_LEVEL: en_level_reg <= pwdata[0];
                REG_INIT_NUM: init_num_reg <= pwdata[15:0];
                REG_INIT_DEN: init_den_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_STEP_NUM: prdata = {16'd0, step_num_reg};
            REG_STEP_DEN: prdata = {16'd0, step_den_reg};
            REG_FULL:     prdata = {16'd0, full_reg};
            REG_DIR_INV:  prdata = {31'd0, dir_inv_reg};
            REG_EN_LEVEL: prdata = {31'd0, en_level_reg};
            REG_INIT_NUM: prdata = {16'd0, init_num_reg};
            REG_INIT_DEN: prdata = {16'd0, init_den_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // A write to either initial angle register also reloads the current angle.
    assign cfg.step_num   = step_num_reg;
    assign cfg.step_den   = step_den_reg;
    assign cfg.full_angle = full_reg;
    assign cfg.dir_invert = dir_inv_reg;
    assign cfg.en_active  = en_level_reg;
    assign cfg.load_num   = wr && (idx == REG_INIT_NUM);
    assign cfg.load_den   = wr && (idx == REG_INIT_DEN);
    assign cfg.init_num   = pwdata[15:0];
    assign cfg.init_den   = pwdata[15:0];

endmodule

// File: rtl/sfpc_dp.sv
`timescale 1ns / 1ps

module sfpc_dp import sfpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  ctl_t               ctl,
    input  logic [1:0]         in_command,
    input  logic signed [15:0] in_target_num,
    input  logic signed [15:0] in_target_den,
    input  logic               in_pulses_running,
    output sts_t               sts,
    output logic [23:0]        res_data
);

    // Captured command.
    logic        [1:0]  cmd_reg;
    logic signed [15:0] tn_reg;
    logic signed [15:0] td_reg;
    logic               run_reg;

    // Block state.
    logic signed [15:0] cur_num_reg;
    logic signed [15:0] cur_den_reg;
    logic               dir_pin_reg;
    logic               en_pin_reg;

    // Products.
    logic signed [32:0] prod_reg;
    logic signed [32:0] dnum_reg;
    logic signed [32:0] dden_reg;
    logic signed [32:0] fs_reg;
    logic signed [46:0] dv_reg;
    logic signed [63:0] top_reg;

    // Divider.
    logic        [63:0] quo_reg;
    logic        [45:0] rem_reg;
    logic        [45:0] div_reg;
    logic               neg_reg;

    logic        [23:0] res_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [63:0] top_neg;
    logic signed [46:0] dv_neg;
    logic        [46:0] rem_sh;
    logic               ge;

    logic               status_c;
    logic               dir_c;
    logic               en_c;
    logic               start_c;
    logic        [15:0] count_c;
    logic               stop_c;

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg <= in_command;
            tn_reg  <= in_target_num;
            td_reg  <= in_target_den;
            run_reg <= in_pulses_running;
        end
    end

    assign sts.cmd        = cmd_reg;
    assign sts.reject     = (td_reg == 16'sd0) || run_reg;
    assign sts.degenerate = (cur_den_reg == 16'sd0) || (cfg.step_num == 16'sd0);

    // One shared signed multiplier, stepped through the cross-multiply.
    always_comb begin
        unique case (ctl.mul_op)
            MUL_TN_CD: begin
                mul_a = {{17{tn_reg[15]}}, tn_reg};
                mul_b = {{17{cur_den_reg[15]}}, cur_den_reg};
            end
            MUL_DNUM: begin
                mul_a = {{17{cur_num_reg[15]}}, cur_num_reg};
                mul_b = {{17{td_reg[15]}}, td_reg};
            end
            MUL_DDEN: begin
                mul_a = {{17{td_reg[15]}}, td_reg};
                mul_b = {{17{cur_den_reg[15]}}, cur_den_reg};
            end
            MUL_FS: begin
                mul_a = {17'd0, cfg.full_angle};
                mul_b = {{17{cfg.step_den[15]}}, cfg.step_den};
            end
            MUL_DV: begin
                mul_a = dden_reg;
                mul_b = {{17{cfg.step_num[15]}}, cfg.step_num};
            end
            MUL_TOP: begin
                mul_a = dnum_reg;
                mul_b = fs_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            unique case (ctl.mul_op)
                MUL_TN_CD: prod_reg <= mul_p[32:0];
                MUL_DNUM:  dnum_reg <= prod_reg - mul_p[32:0];
                MUL_DDEN:  dden_reg <= mul_p[32:0];
                MUL_FS:    fs_reg   <= mul_p[32:0];
                MUL_DV:    dv_reg   <= mul_p[46:0];
                MUL_TOP:   top_reg  <= mul_p[63:0];
                default: ;
            endcase
        end
    end

    // Restoring division on magnitudes; the sign of the quotient sets the direction pin.
    assign top_neg = -top_reg;
    assign dv_neg  = -dv_reg;
    assign rem_sh  = {rem_reg, quo_reg[63]};
    assign ge      = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (ctl.abs_en) begin
            quo_reg <= top_reg[63] ? top_neg : top_reg;
            div_reg <= dv_reg[46] ? dv_neg[45:0] : dv_reg[45:0];
            rem_reg <= '0;
            neg_reg <= top_reg[63] ^ dv_reg[46];
        end else if (ctl.div_step) begin
            rem_reg <= ge ? 46'(rem_sh - {1'b0, div_reg}) : rem_sh[45:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    // Outcome of the captured command.
    always_comb begin
        status_c = 1'b0;
        dir_c    = dir_pin_reg;
        en_c     = en_pin_reg;
        start_c  = 1'b0;
        count_c  = 16'd0;
        stop_c   = 1'b0;
        unique case (cmd_reg)
            CMD_POWER_ON: begin
                en_c  = cfg.en_active;
                dir_c = ~cfg.dir_invert;
            end
            CMD_SHUT_DOWN: begin
                stop_c = 1'b1;
                en_c   = ~cfg.en_active;
            end
            CMD_MOVE: begin
                if (sts.reject) begin
                    status_c = 1'b1;
                end else if (!sts.degenerate && (quo_reg != 64'd0)) begin
                    start_c = 1'b1;
                    count_c = quo_reg[15:0];
                    dir_c   = neg_reg ? cfg.dir_invert : ~cfg.dir_invert;
                end
            end
            CMD_MODE: begin
                status_c = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_num_reg <= 16'sd0;
            cur_den_reg <= 16'sd1;
            dir_pin_reg <= 1'b0;
            en_pin_reg  <= 1'b0;
        end else begin
            if (cfg.load_num) begin
                cur_num_reg <= cfg.init_num;
            end
            if (cfg.load_den) begin
                cur_den_reg <= cfg.init_den;
            end
            if (ctl.commit) begin
                dir_pin_reg <= dir_c;
                en_pin_reg  <= en_c;
                if ((cmd_reg == CMD_MOVE) && !sts.reject) begin
                    cur_num_reg <= tn_reg;
                    cur_den_reg <= td_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            res_reg <= {3'd0, stop_c, count_c, start_c, en_c, dir_c, status_c};
        end
    end

    assign res_data = res_reg;

endmodule

// File: rtl/sfpc_ctrl.sv
`timescale 1ns / 1ps

module sfpc_ctrl import sfpc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_TN_CD  = 4'd2;
    localparam logic [3:0] ST_DNUM   = 4'd3;
    localparam logic [3:0] ST_DDEN   = 4'd4;
    localparam logic [3:0] ST_FS     = 4'd5;
    localparam logic [3:0] ST_DV     = 4'd6;
    localparam logic [3:0] ST_TOP    = 4'd7;
    localparam logic [3:0] ST_ABS    = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [5:0] cnt_reg;
    logic [5:0] cnt_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctl           = '0;
        ctl.mul_op    = MUL_TN_CD;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((sts.cmd == CMD_MOVE) && !sts.reject && !sts.degenerate) begin
                    state_next = ST_TN_CD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_TN_CD: begin
                ctl.mul_en = 1'b1;
                ctl.mul_op = MUL_TN_CD;
                state_next = ST_DNUM;
            end
            ST_DNUM: begin
                ctl.mul_en = 1'b1;
                ctl.mul_op = MUL_DNUM;
                state_next = ST_DDEN;
            end
            ST_DDEN: begin
                ctl.mul_en = 1'b1;
                ctl.mul_op = MUL_DDEN;
                state_next = ST_FS;
            end
            ST_FS: begin
                ctl.mul_en = 1'b1;
                ctl.mul_op = MUL_FS;
                state_next = ST_DV;
            end
            ST_DV: begin
                ctl.mul_en = 1'b1;
                ctl.mul_op = MUL_DV;
                state_next = ST_TOP;
            end
            ST_TOP: begin
                ctl.mul_en = 1'b1;
                ctl.mul_op = MUL_TOP;
                state_next = ST_ABS;
            end
            ST_ABS: begin
                ctl.abs_en = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == '1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ctl.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: rtl/stepper_fraction_position_commander_core.sv
`timescale 1ns / 1ps

// Stepper position commander. Each input beat carries one command in s_tuser (power on, shut
// down, move to position, or an unsupported mode request) and, for a move, a target angle given
// as the fraction target_num/target_den of full_angle. Every command yields exactly one result
// beat with the status and the levels for the direction and enable pins, plus the burst request
// for the external pulse generator. A move works out the step count as
// (tn*cd - cn*td) * full_angle * step_den / (td*cd * step_num), truncated toward zero, on one
// shared signed 33 by 33 bit multiplier (six products, one a cycle) and a restoring divider that
// produces one quotient bit a cycle for a 64-bit quotient; a move that is neither rejected nor
// degenerate runs these steps, while any other command goes straight to its result beat.
// The block works on one command at a time; the next input beat is taken as soon as the previous
// result has been placed in the output register, even while that result still waits for
// m_tready. Moves are rejected when the target denominator is zero or pulses are still running.
// Registers must be written over the APB port only while the block is idle; the block itself
// does not enforce this. Writing an initial angle register also reloads the current angle.

module stepper_fraction_position_commander_core import sfpc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // target_num[15:0], target_den[31:16],
                                           // pulses_running[32], zero fill
    input  logic [1:0]          s_tuser,   // command[1:0]
    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // status[0], dir_level[1], enable_level[2],
                                           // start_pulses[3], pulse_count[19:4],
                                           // stop_pulses[20], zero fill
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cfg_t cfg;
    ctl_t ctl;
    sts_t sts;

    // The register file never inserts wait states.
    assign pready = 1'b1;

    sfpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The controller sequences the multiplier steps and the divider and owns both handshakes.
    sfpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // The datapath holds the current angle, the pin levels and the result register.
    sfpc_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .ctl               (ctl),
        .in_command        (s_tuser),
        .in_target_num     (s_tdata[15:0]),
        .in_target_den     (s_tdata[31:16]),
        .in_pulses_running (s_tdata[32]),
        .sts               (sts),
        .res_data          (m_tdata)
    );

endmodule

// File: rtl/sfpc_checker.sv
`timescale 1ns / 1ps

module sfpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result beat stays and holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A burst request only comes with an accepted move, never with a shut down.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[0] && !m_tdata[20])
        else $error("burst requested on a rejected command or a shut down");

    // Without a burst the pulse count reads zero.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> (m_tdata[19:4] == 16'd0))
        else $error("pulse count without a burst");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

endmodule

bind stepper_fraction_position_commander_core sfpc_checker u_sfpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
